/* src/length_prefixed_packet_ring_core_assert.svh */
// Assertion macros used by the packet ring back end.
`ifndef LENGTH_PREFIXED_PACKET_RING_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_PACKET_RING_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LPR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define LPR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* src/lpr_pkg.sv */
// Types, codes and constants for the length-prefixed packet ring.
`timescale 1ns / 1ps

package lpr_pkg;

  localparam int RING_AW    = 12;
  localparam int RING_BYTES = 1 << RING_AW;

  localparam logic [12:0] RING_SIZE   = 13'(RING_BYTES);
  localparam logic [12:0] BSIZE_RESET = 13'd4096;

  typedef logic [RING_AW-1:0] lpr_addr_t;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_NEXT  = 2'd2;
  localparam logic [1:0] ACT_BYTE  = 2'd3;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_EMPTY   = 3'd1;
  localparam logic [2:0] STAT_LONG    = 3'd2;
  localparam logic [2:0] STAT_TRASH   = 3'd3;
  localparam logic [2:0] STAT_OVERRUN = 3'd4;
  localparam logic [2:0] STAT_UNEXP   = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] packet_length;
    logic [7:0]  data_byte;
    logic [11:0] read_offset;
  } lpr_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] length_out;
    logic [11:0] data_offset;
    logic [7:0]  byte_out;
  } lpr_out_t;

  typedef enum logic [2:0] {
    K_START,
    K_EMPTY,
    K_DATA,
    K_NEXT,
    K_BYTE
  } lpr_kind_t;

  typedef struct packed {
    lpr_kind_t   kind;
    logic [15:0] len;
    logic [7:0]  dbyte;
    logic [11:0] roff;
  } lpr_cmd_t;

  typedef struct packed {
    logic     valid;
    lpr_cmd_t cmd;
  } lpr_qhead_t;

endpackage

/* src/lpr_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/lpr_front.sv */
// Front end: accepts words, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module lpr_front import lpr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  lpr_in_t    in_data,
  output lpr_qhead_t head,
  input  logic       pop
);

  lpr_cmd_t   q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       take;
  lpr_cmd_t   cmd;

  always_comb begin
    cmd.len   = in_data.packet_length;
    cmd.dbyte = in_data.data_byte;
    cmd.roff  = in_data.read_offset;
    case (in_data.action)
      ACT_START: cmd.kind = (in_data.packet_length == 16'd0) ? K_EMPTY : K_START;
      ACT_DATA:  cmd.kind = K_DATA;
      ACT_NEXT:  cmd.kind = K_NEXT;
      ACT_BYTE:  cmd.kind = K_BYTE;
      default:   cmd.kind = K_BYTE;
    endcase
  end

  assign busy = (count_r == 2'd2);
  assign push = start && !busy;
  assign take = pop && (count_r != 2'd0);

  assign head.valid = (count_r != 2'd0);
  assign head.cmd   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = take ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

/* src/lpr_back.sv */
// Back end: executes queued words against the ring pointers and the byte store.
`timescale 1ns / 1ps

`include "length_prefixed_packet_ring_core_assert.svh"

module lpr_back import lpr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  lpr_qhead_t  head,
  output logic        pop,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,
  output logic        ram_we,
  output lpr_addr_t   ram_addr,
  output logic [7:0]  ram_wdata,
  input  logic [7:0]  ram_rdata,
  output logic        out_valid,
  output lpr_out_t    out_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MARK0,
    S_MARK1,
    S_HDR0,
    S_HDR1,
    S_DATA,
    S_NXBASE,
    S_RDA,
    S_RDB,
    S_RDC,
    S_BYA,
    S_BYB
  } state_t;

  state_t      state_r, state_nxt;
  lpr_cmd_t    cmd_r, cmd_nxt;
  logic [12:0] wp_r, wp_nxt;
  logic [12:0] rp_r, rp_nxt;
  logic [15:0] prev_r, prev_nxt;
  logic        wrapped_r, wrapped_nxt;
  lpr_addr_t   fp_r, fp_nxt;
  logic [15:0] frem_r, frem_nxt;
  logic [12:0] bsize_r, bsize_nxt;
  lpr_addr_t   addr_r, addr_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic        second_r, second_nxt;
  logic        out_valid_r, out_valid_nxt;
  lpr_out_t    out_r, out_nxt;

  logic [12:0] size;
  logic [17:0] size18, wp18, rp18, len18, need, need_eff, rsum, base;
  logic        wrap, mark, trash, overrun, too_long;
  logic        rd_wrap;
  logic [2:0]  start_stat;
  logic [15:0] rd_len;
  logic        we_state;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pop       = (state_r == S_IDLE) && head.valid;
  assign we_state  = (state_r == S_MARK0) || (state_r == S_MARK1) || (state_r == S_HDR0) ||
                     (state_r == S_HDR1) || (state_r == S_DATA);

  // Start-write and read-next checks, all taken against the pointers as they stand.
  always_comb begin
    size     = (bsize_r > RING_SIZE) ? RING_SIZE : bsize_r;
    size18   = {5'd0, size};
    wp18     = {5'd0, wp_r};
    rp18     = {5'd0, rp_r};
    len18    = {2'd0, cmd_r.len};
    need     = wp18 + len18 + 18'd2;
    too_long = len18 > size18;
    wrap     = need >= size18;
    mark     = wrap && ((wp18 + 18'd2) <= size18);
    trash    = wrap && (rp_r >= wp_r);
    need_eff = wrap ? (len18 + 18'd2) : need;
    overrun  = (wrap || wrapped_r) && (need_eff > rp18);
    if (trash) begin
      start_stat = STAT_TRASH;
    end else if (overrun) begin
      start_stat = STAT_OVERRUN;
    end else begin
      start_stat = STAT_OK;
    end
    rsum    = rp18 + {2'd0, prev_r};
    rd_wrap = (rsum + 18'd2) > size18;
    base    = rd_wrap ? 18'd0 : rsum;
    rd_len  = {ram_rdata, lo_r};
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    prev_nxt      = prev_r;
    wrapped_nxt   = wrapped_r;
    fp_nxt        = fp_r;
    frem_nxt      = frem_r;
    bsize_nxt     = cfg_valid ? cfg_data : bsize_r;
    addr_nxt      = addr_r;
    stat_nxt      = stat_r;
    lo_nxt        = lo_r;
    second_nxt    = second_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_addr      = addr_r;
    ram_wdata     = 8'd0;

    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          cmd_nxt = head.cmd;
          case (head.cmd.kind)
            K_START: state_nxt = S_CHECK;
            K_EMPTY: state_nxt = S_CHECK;
            K_DATA:  state_nxt = S_DATA;
            K_NEXT:  state_nxt = S_NXBASE;
            K_BYTE:  state_nxt = S_BYA;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        out_nxt = '0;
        if (cmd_r.kind == K_EMPTY) begin
          frem_nxt       = 16'd0;
          out_nxt.status = STAT_EMPTY;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (too_long) begin
          frem_nxt       = 16'd0;
          out_nxt.status = STAT_LONG;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          // The marker goes at the old write point; the header at the new one.
          addr_nxt = (wrap && !mark) ? '0 : wp_r[RING_AW-1:0];
          if (wrap && !trash) begin
            wp_nxt      = 13'd0;
            wrapped_nxt = 1'b1;
          end
          stat_nxt = start_stat;
          if (start_stat != STAT_OK) begin
            frem_nxt = 16'd0;
          end
          if (mark) begin
            state_nxt = S_MARK0;
          end else if (start_stat == STAT_OK) begin
            state_nxt = S_HDR0;
          end else begin
            out_nxt.status = start_stat;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_MARK0: begin
        ram_we    = 1'b1;
        addr_nxt  = addr_r + lpr_addr_t'(1);
        state_nxt = S_MARK1;
      end
      S_MARK1: begin
        ram_we = 1'b1;
        if (stat_r == STAT_OK) begin
          addr_nxt  = wp_r[RING_AW-1:0];
          state_nxt = S_HDR0;
        end else begin
          out_nxt        = '0;
          out_nxt.status = stat_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_HDR0: begin
        ram_we    = 1'b1;
        ram_wdata = cmd_r.len[7:0];
        addr_nxt  = addr_r + lpr_addr_t'(1);
        state_nxt = S_HDR1;
      end
      S_HDR1: begin
        ram_we         = 1'b1;
        ram_wdata      = cmd_r.len[15:8];
        fp_nxt         = addr_r + lpr_addr_t'(1);
        frem_nxt       = cmd_r.len;
        wp_nxt         = need[12:0];
        out_nxt        = '0;
        out_nxt.status = STAT_OK;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_DATA: begin
        out_nxt = '0;
        if (frem_r == 16'd0) begin
          out_nxt.status = STAT_UNEXP;
        end else begin
          ram_we         = 1'b1;
          ram_addr       = fp_r;
          ram_wdata      = cmd_r.dbyte;
          fp_nxt         = fp_r + lpr_addr_t'(1);
          frem_nxt       = frem_r - 16'd1;
          out_nxt.status = STAT_OK;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_NXBASE: begin
        if (rd_wrap) begin
          wrapped_nxt = 1'b0;
        end
        addr_nxt   = base[RING_AW-1:0];
        rp_nxt     = base[12:0] + 13'd2;
        second_nxt = 1'b0;
        state_nxt  = S_RDA;
      end
      S_RDA: begin
        addr_nxt  = addr_r + lpr_addr_t'(1);
        state_nxt = S_RDB;
      end
      S_RDB: begin
        lo_nxt    = ram_rdata;
        state_nxt = S_RDC;
      end
      S_RDC: begin
        // A zero length is the writer's wrap marker: restart at offset 0 once.
        if ((rd_len == 16'd0) && !second_r) begin
          wrapped_nxt = 1'b0;
          rp_nxt      = 13'd2;
          addr_nxt    = '0;
          second_nxt  = 1'b1;
          state_nxt   = S_RDA;
        end else begin
          prev_nxt            = rd_len;
          out_nxt             = '0;
          out_nxt.status      = STAT_OK;
          out_nxt.length_out  = rd_len;
          out_nxt.data_offset = rp_r[11:0];
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      S_BYA: begin
        ram_addr  = cmd_r.roff;
        state_nxt = S_BYB;
      end
      S_BYB: begin
        out_nxt          = '0;
        out_nxt.status   = STAT_OK;
        out_nxt.byte_out = ram_rdata;
        out_valid_nxt    = 1'b1;
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= 13'd0;
      rp_r        <= 13'd0;
      prev_r      <= 16'd0;
      wrapped_r   <= 1'b0;
      fp_r        <= '0;
      frem_r      <= 16'd0;
      bsize_r     <= BSIZE_RESET;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      prev_r      <= prev_nxt;
      wrapped_r   <= wrapped_nxt;
      fp_r        <= fp_nxt;
      frem_r      <= frem_nxt;
      bsize_r     <= bsize_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r  <= cmd_nxt;
    addr_r <= addr_nxt;
    stat_r <= stat_nxt;
    lo_r   <= lo_nxt;
    out_r  <= out_nxt;
  end

  `LPR_ASSERT_NXT(a_strobe_single, out_valid_r, !out_valid_r)
  `LPR_ASSERT_NXT(a_pop_leaves_idle, pop, state_r != S_IDLE)
  `LPR_ASSERT_IMP(a_we_states, ram_we, we_state)
  `LPR_ASSERT_IMP(a_ptr_bound, 1'b1, (wp_r <= RING_SIZE) && (rp_r <= RING_SIZE))

endmodule

/* src/length_prefixed_packet_ring_core.sv */
// With the back end idle, a queued word runs its states, then the result strobe rises:
// data byte S_DATA; read byte S_BYA, S_BYB; start write S_CHECK, S_MARK0, S_MARK1 for a wrap
// marker, S_HDR0, S_HDR1 for the header; read next S_NXBASE, S_RDA, S_RDB, S_RDC, once more from
// S_RDA at a marker. The byte-wide port takes one header byte per access; reads are registered.
// A two-word queue lets start be taken while the back end works; results cannot be stalled.
// Synchronous active-low reset clears pointers and sets buffer_size to 4096; store unchanged.
`timescale 1ns / 1ps

module length_prefixed_packet_ring_core import lpr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  lpr_in_t     in_data,
  output logic        out_valid,
  output lpr_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);

  lpr_qhead_t head;
  logic       pop;
  logic       ram_we;
  lpr_addr_t  ram_addr;
  logic [7:0] ram_wdata;
  logic [7:0] ram_rdata;

  lpr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .head    (head),
    .pop     (pop)
  );

  lpr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  lpr_ram #(
    .WIDTH (8),
    .DEPTH (RING_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule
